// ===== sv/qvr_pkg.sv =====
// Shared types, constants and helper functions for the quaternion vector rotation unit.
// Depends on nothing; the other files, apart from the two channel interfaces, refer to it by scoped names.

package qvr_pkg;

    // Default widths of the vector fields and the quaternion fraction.
    localparam int VEC_WIDTH      = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int QUAT_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_QUAT_X = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_QUAT_Y = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_QUAT_Z = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_QUAT_W = 2'd3;

    // Reset value of the scalar part: 1.0 in Q1.14.
    localparam logic signed [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'sd16384;

    // Quaternion as held in the configuration registers.
    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] x;
        logic signed [QUAT_WIDTH-1:0] y;
        logic signed [QUAT_WIDTH-1:0] z;
        logic signed [QUAT_WIDTH-1:0] w;
    } t_quat;

    // Width of the intermediate product t = q * (0, v) after rounding.
    // The unrounded sum of three products fits in vw + 17 bits.
    function automatic int t_width(input int vw, input int qf);
        int w;
        w = vw + 18 - qf;
        if (w < 2) begin
            w = 2;
        end
        return w;
    endfunction

endpackage

// ===== sv/qvr_vec_if.sv =====
// Valid/ready channel that carries one input vector per transfer.
// Depends on nothing.

interface qvr_vec_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] vec_x;
    logic signed [W-1:0] vec_y;
    logic signed [W-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// ===== sv/qvr_rot_if.sv =====
// Valid/ready channel that carries one rotated vector and its saturation flag per transfer.
// Depends on nothing.

interface qvr_rot_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rot_x;
    logic signed [W-1:0] rot_y;
    logic signed [W-1:0] rot_z;
    logic                clipped;

    modport source (output valid, output rot_x, output rot_y, output rot_z, output clipped,
                    input ready);
    modport sink   (input valid, input rot_x, input rot_y, input rot_z, input clipped,
                    output ready);
endinterface

// ===== sv/qvr_cfg_regs.sv =====
// Configuration registers that hold the rotation quaternion.
// Depends on qvr_pkg for the register indexes and the quaternion type.

module qvr_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [qvr_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]       i_cfg_data,
    output qvr_pkg::t_quat                       o_quat
);

    qvr_pkg::t_quat r_quat;

    // Reset gives the identity rotation; a write updates one component.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
            r_quat.w <= qvr_pkg::QUAT_W_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qvr_pkg::REG_QUAT_X: r_quat.x <= i_cfg_data;
                qvr_pkg::REG_QUAT_Y: r_quat.y <= i_cfg_data;
                qvr_pkg::REG_QUAT_Z: r_quat.z <= i_cfg_data;
                qvr_pkg::REG_QUAT_W: r_quat.w <= i_cfg_data;
                default:             r_quat   <= r_quat;
            endcase
        end
    end

    assign o_quat = r_quat;

endmodule

// ===== sv/qvr_fwd_stage.sv =====
// First Hamilton product t = q * (0, v): a multiply stage and a sum-and-round stage.
// Depends on qvr_pkg for the quaternion type and the intermediate width.

module qvr_fwd_stage #(
    parameter int VW = qvr_pkg::VEC_WIDTH,
    parameter int QF = qvr_pkg::QUAT_FRAC_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  qvr_pkg::t_quat                              i_quat,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic signed [VW-1:0]                        i_vec_x,
    input  logic signed [VW-1:0]                        i_vec_y,
    input  logic signed [VW-1:0]                        i_vec_z,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic signed [qvr_pkg::t_width(VW, QF)-1:0]  o_t_w,
    output logic signed [qvr_pkg::t_width(VW, QF)-1:0]  o_t_x,
    output logic signed [qvr_pkg::t_width(VW, QF)-1:0]  o_t_y,
    output logic signed [qvr_pkg::t_width(VW, QF)-1:0]  o_t_z
);

    localparam int TW = qvr_pkg::t_width(VW, QF);
    localparam int PW = VW + qvr_pkg::QUAT_WIDTH;
    localparam int SW = VW + 18;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (QF - 1);

    logic r_a_valid;
    logic r_b_valid;
    logic a_ready;
    logic b_ready;

    logic signed [PW-1:0] r_wvx, r_wvy, r_wvz;
    logic signed [PW-1:0] r_xvx, r_xvy, r_xvz;
    logic signed [PW-1:0] r_yvx, r_yvy, r_yvz;
    logic signed [PW-1:0] r_zvx, r_zvy, r_zvz;

    logic signed [SW-1:0] n_s_w, n_s_x, n_s_y, n_s_z;
    logic signed [SW-1:0] n_h_w, n_h_x, n_h_y, n_h_z;
    logic signed [TW-1:0] r_t_w, r_t_x, r_t_y, r_t_z;

    // A stage takes a new item when it is empty or its contents move on.
    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Multiply stage: every quaternion component times every vector component.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_wvx <= i_quat.w * i_vec_x;
            r_wvy <= i_quat.w * i_vec_y;
            r_wvz <= i_quat.w * i_vec_z;
            r_xvx <= i_quat.x * i_vec_x;
            r_xvy <= i_quat.x * i_vec_y;
            r_xvz <= i_quat.x * i_vec_z;
            r_yvx <= i_quat.y * i_vec_x;
            r_yvy <= i_quat.y * i_vec_y;
            r_yvz <= i_quat.y * i_vec_z;
            r_zvx <= i_quat.z * i_vec_x;
            r_zvy <= i_quat.z * i_vec_y;
            r_zvz <= i_quat.z * i_vec_z;
        end
    end

    // Sum stage: exact sums with the rounding offset, then an arithmetic shift.
    always_comb begin
        n_s_w = RND - SW'(r_xvx) - SW'(r_yvy) - SW'(r_zvz);
        n_s_x = RND + SW'(r_wvx) + SW'(r_yvz) - SW'(r_zvy);
        n_s_y = RND + SW'(r_wvy) + SW'(r_zvx) - SW'(r_xvz);
        n_s_z = RND + SW'(r_wvz) + SW'(r_xvy) - SW'(r_yvx);
        n_h_w = n_s_w >>> QF;
        n_h_x = n_s_x >>> QF;
        n_h_y = n_s_y >>> QF;
        n_h_z = n_s_z >>> QF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_t_w <= n_h_w[TW-1:0];
            r_t_x <= n_h_x[TW-1:0];
            r_t_y <= n_h_y[TW-1:0];
            r_t_z <= n_h_z[TW-1:0];
        end
    end

    assign o_valid = r_b_valid;
    assign o_t_w   = r_t_w;
    assign o_t_x   = r_t_x;
    assign o_t_y   = r_t_y;
    assign o_t_z   = r_t_z;

endmodule

// ===== sv/qvr_rev_stage.sv =====
// Second Hamilton product r = t * conj(q), vector part: a multiply stage and a
// sum, round and saturate stage whose register is the output register.
// Depends on qvr_pkg for the quaternion type and the intermediate width.

module qvr_rev_stage #(
    parameter int VW = qvr_pkg::VEC_WIDTH,
    parameter int QF = qvr_pkg::QUAT_FRAC_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  qvr_pkg::t_quat                              i_quat,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic signed [qvr_pkg::t_width(VW, QF)-1:0]  i_t_w,
    input  logic signed [qvr_pkg::t_width(VW, QF)-1:0]  i_t_x,
    input  logic signed [qvr_pkg::t_width(VW, QF)-1:0]  i_t_y,
    input  logic signed [qvr_pkg::t_width(VW, QF)-1:0]  i_t_z,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic signed [VW-1:0]                        o_rot_x,
    output logic signed [VW-1:0]                        o_rot_y,
    output logic signed [VW-1:0]                        o_rot_z,
    output logic                                        o_clipped
);

    localparam int TW = qvr_pkg::t_width(VW, QF);
    localparam int PW = TW + qvr_pkg::QUAT_WIDTH;
    localparam int SW = TW + 19;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (QF - 1);
    localparam logic signed [SW-1:0] HI  = SW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] LO  = SW'(-(64'sd1 <<< (VW - 1)));

    logic r_c_valid;
    logic r_d_valid;
    logic c_ready;
    logic d_ready;

    logic signed [PW-1:0] r_w_tx, r_w_ty, r_w_tz;
    logic signed [PW-1:0] r_tw_x, r_tw_y, r_tw_z;
    logic signed [PW-1:0] r_y_tz, r_z_ty, r_z_tx;
    logic signed [PW-1:0] r_x_tz, r_x_ty, r_y_tx;

    logic signed [SW-1:0] n_s_x, n_s_y, n_s_z;
    logic signed [SW-1:0] n_h_x, n_h_y, n_h_z;
    logic                 n_hi_x, n_hi_y, n_hi_z;
    logic                 n_lo_x, n_lo_y, n_lo_z;
    logic signed [VW-1:0] n_rot_x, n_rot_y, n_rot_z;
    logic                 n_clipped;

    logic signed [VW-1:0] r_rot_x, r_rot_y, r_rot_z;
    logic                 r_clipped;

    assign d_ready = !r_d_valid || i_ready;
    assign c_ready = !r_c_valid || d_ready;
    assign o_ready = c_ready;

    // Multiply stage: the twelve products that the vector part needs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && i_valid) begin
            r_w_tx <= i_quat.w * i_t_x;
            r_w_ty <= i_quat.w * i_t_y;
            r_w_tz <= i_quat.w * i_t_z;
            r_tw_x <= i_quat.x * i_t_w;
            r_tw_y <= i_quat.y * i_t_w;
            r_tw_z <= i_quat.z * i_t_w;
            r_y_tz <= i_quat.y * i_t_z;
            r_z_ty <= i_quat.z * i_t_y;
            r_z_tx <= i_quat.z * i_t_x;
            r_x_tz <= i_quat.x * i_t_z;
            r_x_ty <= i_quat.x * i_t_y;
            r_y_tx <= i_quat.y * i_t_x;
        end
    end

    // Sum, round and clamp each component to the vector range.
    always_comb begin
        n_s_x = RND + SW'(r_w_tx) - SW'(r_tw_x) + SW'(r_y_tz) - SW'(r_z_ty);
        n_s_y = RND + SW'(r_w_ty) - SW'(r_tw_y) + SW'(r_z_tx) - SW'(r_x_tz);
        n_s_z = RND + SW'(r_w_tz) - SW'(r_tw_z) + SW'(r_x_ty) - SW'(r_y_tx);
        n_h_x = n_s_x >>> QF;
        n_h_y = n_s_y >>> QF;
        n_h_z = n_s_z >>> QF;
        n_hi_x = n_h_x > HI;
        n_hi_y = n_h_y > HI;
        n_hi_z = n_h_z > HI;
        n_lo_x = n_h_x < LO;
        n_lo_y = n_h_y < LO;
        n_lo_z = n_h_z < LO;
        n_rot_x = n_hi_x ? HI[VW-1:0] : (n_lo_x ? LO[VW-1:0] : n_h_x[VW-1:0]);
        n_rot_y = n_hi_y ? HI[VW-1:0] : (n_lo_y ? LO[VW-1:0] : n_h_y[VW-1:0]);
        n_rot_z = n_hi_z ? HI[VW-1:0] : (n_lo_z ? LO[VW-1:0] : n_h_z[VW-1:0]);
        n_clipped = n_hi_x || n_hi_y || n_hi_z || n_lo_x || n_lo_y || n_lo_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_ready) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_ready && r_c_valid) begin
            r_rot_x   <= n_rot_x;
            r_rot_y   <= n_rot_y;
            r_rot_z   <= n_rot_z;
            r_clipped <= n_clipped;
        end
    end

    assign o_valid   = r_d_valid;
    assign o_rot_x   = r_rot_x;
    assign o_rot_y   = r_rot_y;
    assign o_rot_z   = r_rot_z;
    assign o_clipped = r_clipped;

endmodule

// ===== sv/quaternion_vector_rotate_unit.sv =====
// Quaternion vector rotation unit: rotates each vector by q * (0, v) * conj(q).
// An input vector passes the forward multiply, forward sum, reverse multiply and reverse sum stages to the output.
// Throughput: one vector per cycle while the output is not stalled, set by the
// four-stage pipeline with a per-stage valid; a stalled output holds its result and fills the stages behind it.
// Reset clears every stage's valid bit and loads the identity quaternion.
// Depends on qvr_pkg, qvr_vec_if, qvr_rot_if, qvr_cfg_regs, qvr_fwd_stage, qvr_rev_stage.

module quaternion_vector_rotate_unit #(
    parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qvr_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]    i_cfg_data,
    qvr_vec_if.sink                           i_vec,
    qvr_rot_if.source                         o_rot
);

    localparam int TW = qvr_pkg::t_width(VEC_WIDTH, QUAT_FRAC_BITS);

    qvr_pkg::t_quat       quat;
    logic                 t_valid;
    logic                 t_ready;
    logic signed [TW-1:0] t_w, t_x, t_y, t_z;

    // Quaternion registers.
    qvr_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_quat     (quat)
    );

    // First product, two stages.
    qvr_fwd_stage #(
        .VW (VEC_WIDTH),
        .QF (QUAT_FRAC_BITS)
    ) u_fwd_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat),
        .i_valid (i_vec.valid),
        .o_ready (i_vec.ready),
        .i_vec_x (i_vec.vec_x),
        .i_vec_y (i_vec.vec_y),
        .i_vec_z (i_vec.vec_z),
        .o_valid (t_valid),
        .i_ready (t_ready),
        .o_t_w   (t_w),
        .o_t_x   (t_x),
        .o_t_y   (t_y),
        .o_t_z   (t_z)
    );

    // Second product and saturation, two stages.
    qvr_rev_stage #(
        .VW (VEC_WIDTH),
        .QF (QUAT_FRAC_BITS)
    ) u_rev_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_quat    (quat),
        .i_valid   (t_valid),
        .o_ready   (t_ready),
        .i_t_w     (t_w),
        .i_t_x     (t_x),
        .i_t_y     (t_y),
        .i_t_z     (t_z),
        .o_valid   (o_rot.valid),
        .i_ready   (o_rot.ready),
        .o_rot_x   (o_rot.rot_x),
        .o_rot_y   (o_rot.rot_y),
        .o_rot_z   (o_rot.rot_z),
        .o_clipped (o_rot.clipped)
    );

endmodule

// ===== sv/qvr_checker.sv =====
// Port-level checks for the quaternion vector rotation unit, and the bind that attaches them.
// Depends on quaternion_vector_rotate_unit and its interface channels.

module qvr_checker #(
    parameter int VW = qvr_pkg::VEC_WIDTH
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic signed [VW-1:0] i_rot_x,
    input logic signed [VW-1:0] i_rot_y,
    input logic signed [VW-1:0] i_rot_z,
    input logic                i_clipped
);

    localparam logic [VW-1:0] SAT_HI = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] SAT_LO = {1'b1, {(VW-1){1'b0}}};

    // No result may appear straight out of reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid in the cycle after reset");

    // A stalled result keeps its payload until the transfer.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rot_x) && $stable(i_rot_y)
            && $stable(i_rot_z) && $stable(i_clipped))
        else $error("stalled result changed");

    // With the output free flowing, an accepted vector is checked to come out as a valid result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
            |=> i_out_valid)
        else $error("result missing after pipeline latency");

    // A clipped result has at least one component sitting on a range bound.
    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_clipped |->
            (i_rot_x == SAT_HI) || (i_rot_x == SAT_LO) || (i_rot_y == SAT_HI)
            || (i_rot_y == SAT_LO) || (i_rot_z == SAT_HI) || (i_rot_z == SAT_LO))
        else $error("clipped flag without a saturated component");

endmodule

bind quaternion_vector_rotate_unit qvr_checker #(
    .VW (VEC_WIDTH)
) u_qvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vec.valid),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_rot.valid),
    .i_out_ready (o_rot.ready),
    .i_rot_x     (o_rot.rot_x),
    .i_rot_y     (o_rot.rot_y),
    .i_rot_z     (o_rot.rot_z),
    .i_clipped   (o_rot.clipped)
);
